[src/pal_pkg.sv]
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants of the positional array list
// Action and status codes, cell control type and default parameter values.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  localparam int unsigned DefaultDepth     = 128;
  localparam int unsigned DefaultWordWidth = 32;

  localparam int unsigned ActionW  = 3;
  localparam int unsigned PosW     = 7;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned LengthW  = 8;
  localparam int unsigned StatusW  = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_APPEND  = 3'd1,
    ACT_DELETE  = 3'd2,
    ACT_GET     = 3'd3,
    ACT_REPLACE = 3'd4,
    ACT_CLEAR   = 3'd5
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_WRITE,
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     rd_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

[src/pal_cell.sv]
// ----------------------------------------------------------------------------
// pal_cell: one list entry
// Holds one word; shifts from its neighbors, takes a write or clears, and
// drives its word onto the read bus when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_cell
  import pal_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = DefaultWordWidth,
  parameter int unsigned IDX_W      = PosW,
  parameter int unsigned INDEX      = 0
) (
  input  wire logic                  clk_i,
  input  wire cell_ctl_t             ctl_i,
  input  wire logic [IDX_W-1:0]      pos_i,
  input  wire logic [WORD_WIDTH-1:0] value_i,
  input  wire logic [WORD_WIDTH-1:0] left_i,
  input  wire logic [WORD_WIDTH-1:0] right_i,
  output logic      [WORD_WIDTH-1:0] data_o,
  output logic      [WORD_WIDTH-1:0] rd_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [WORD_WIDTH-1:0] data_q, data_d;
  logic                  at_pos, above;

  assign at_pos = (MyIdx == pos_i);
  assign above  = (MyIdx > pos_i);

  always_comb begin
    data_d = data_q;
    unique case (ctl_i.op)
      CELL_HOLD: ;
      CELL_SHIFT_UP: begin
        if (above) begin
          data_d = left_i;
        end else if (at_pos) begin
          data_d = value_i;
        end
      end
      CELL_SHIFT_DOWN: begin
        if (above || at_pos) begin
          data_d = right_i;
        end
      end
      CELL_WRITE: begin
        if (at_pos) begin
          data_d = value_i;
        end
      end
      CELL_CLEAR: data_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (ctl_i.rd_en && at_pos) ? data_q : '0;

endmodule

`default_nettype wire

[src/positional_array_list.sv]
// ----------------------------------------------------------------------------
// positional_array_list: ordered list of signed words with positional access
// Insert, append, delete, get, replace and clear on a row of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries action_i, position_i and
//   value_i. Output channel (out_valid_o / out_stall_i) returns one result
//   per request: read_value_o, length_o and status_o.
//   Every entry sits in its own cell; a whole shift up or down happens in the
//   cycle the request transfers.
//   Latency: the result is valid the cycle after the input transfer.
//   Throughput: one request per cycle while the output is taken; the output
//   register is the only stage, so the input stalls exactly when a result
//   is held and out_stall_i is high.
//   Reset: the list is empty (length zero); no result is pending. Entry
//   contents past the length are never returned.
//   A rejected request (bad position or full list) changes nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list
  import pal_pkg::*;
#(
  parameter int unsigned DEPTH      = DefaultDepth,
  parameter int unsigned WORD_WIDTH = DefaultWordWidth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ActionW-1:0] action_i,
  input  wire logic [PosW-1:0]    position_i,
  input  wire logic [ValueW-1:0]  value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [ValueW-1:0]       read_value_o,
  output logic [LengthW-1:0]      length_o,
  output logic [StatusW-1:0]      status_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned IdxW  = (AddrW > PosW) ? AddrW : PosW;
  localparam int unsigned CmpW  = IdxW + 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  logic [CntW-1:0]       count_q, count_d;
  logic                  out_valid_q;
  logic [ValueW-1:0]     read_value_q, read_value_d;
  logic [LengthW-1:0]    length_q;
  status_e               status_q, status_d;

  cell_ctl_t             ctl;
  logic [IdxW-1:0]       cell_pos;
  logic                  accept, full, pos_gt_cnt, pos_ge_cnt;
  logic [CmpW-1:0]       pos_cmp, cnt_cmp;
  logic [63:0]           value_ext;
  logic [WORD_WIDTH-1:0] wr_word;
  logic signed [WORD_WIDTH-1:0] rd_word;
  logic [63:0]           rd_ext;

  logic [WORD_WIDTH-1:0] cell_data [DEPTH];
  logic [WORD_WIDTH-1:0] cell_rd   [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign value_ext = {{32{value_i[ValueW-1]}}, value_i};
  assign wr_word   = value_ext[WORD_WIDTH-1:0];

  assign full       = (count_q == CntW'(DEPTH));
  assign pos_cmp    = CmpW'(position_i);
  assign cnt_cmp    = CmpW'(count_q);
  assign pos_gt_cnt = (pos_cmp > cnt_cmp);
  assign pos_ge_cnt = (pos_cmp >= cnt_cmp);

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  assign rd_ext = 64'(rd_word);

  always_comb begin
    ctl.op       = CELL_HOLD;
    ctl.rd_en    = 1'b0;
    cell_pos     = IdxW'(position_i);
    count_d      = count_q;
    status_d     = ST_DONE;
    unique case (action_i)
      ACT_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (pos_gt_cnt) begin
          status_d = ST_BAD_POS;
        end else begin
          ctl.op  = CELL_SHIFT_UP;
          count_d = count_q + 1'b1;
        end
      end
      ACT_APPEND: begin
        cell_pos = IdxW'(count_q);
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctl.op  = CELL_WRITE;
          count_d = count_q + 1'b1;
        end
      end
      ACT_DELETE: begin
        if (pos_ge_cnt) begin
          status_d = ST_BAD_POS;
        end else begin
          ctl.op    = CELL_SHIFT_DOWN;
          ctl.rd_en = 1'b1;
          count_d   = count_q - 1'b1;
        end
      end
      ACT_GET: begin
        if (pos_ge_cnt) begin
          status_d = ST_BAD_POS;
        end else begin
          ctl.rd_en = 1'b1;
        end
      end
      ACT_REPLACE: begin
        if (pos_ge_cnt) begin
          status_d = ST_BAD_POS;
        end else begin
          ctl.op = CELL_WRITE;
        end
      end
      ACT_CLEAR: begin
        ctl.op  = CELL_CLEAR;
        count_d = '0;
      end
      default: ;
    endcase
    if (!accept) begin
      ctl.op  = CELL_HOLD;
      count_d = count_q;
    end
  end

  assign read_value_d = rd_ext[ValueW-1:0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    pal_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .IDX_W      (IdxW),
      .INDEX      (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .pos_i   (cell_pos),
      .value_i (wr_word),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .rd_o    (cell_rd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q <= read_value_d;
      length_q     <= LengthW'(count_d);
      status_q     <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign length_o     = length_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire

[src/pal_checker.sv]
// ----------------------------------------------------------------------------
// pal_checker: port-level checks of the positional array list
// Watches both channels and the result codes over time.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_checker
  import pal_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [ValueW-1:0]  read_value_o,
  input wire logic [LengthW-1:0] length_o,
  input wire logic [StatusW-1:0] status_o
);

  property p_in_xfer_gives_result;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && !in_stall_o) |=> out_valid_o;
  endproperty
  a_in_xfer_gives_result: assert property (p_in_xfer_gives_result)
    else $error("transfer in produced no result");

  property p_stall_back;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_stall_i) |-> in_stall_o;
  endproperty
  a_stall_back: assert property (p_stall_back)
    else $error("input open while result is held");

  property p_full_length;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && status_o == ST_FULL) |-> (length_o == LengthW'(DEPTH));
  endproperty
  a_full_length: assert property (p_full_length)
    else $error("list full reported below capacity");

  property p_bad_pos_no_data;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && status_o == ST_BAD_POS) |-> (read_value_o == '0);
  endproperty
  a_bad_pos_no_data: assert property (p_bad_pos_no_data)
    else $error("rejected request returned data");

  property p_result_holds;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_stall_i) |=>
        (out_valid_o && $stable(read_value_o) && $stable(length_o) && $stable(status_o));
  endproperty
  a_result_holds: assert property (p_result_holds)
    else $error("stalled result changed");

endmodule

bind positional_array_list pal_checker #(
  .DEPTH (DEPTH)
) u_pal_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_value_o (read_value_o),
  .length_o     (length_o),
  .status_o     (status_o)
);

`default_nettype wire
